### design/bpts_pkg.sv
// Shared types and constants for the byte pair token statistics block.
`default_nettype none
package bpts_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TOK_W   = 3;
  localparam int unsigned PAIRS_W = 13;
  localparam int unsigned HIST_W  = 16;
  localparam int unsigned EN_W    = 17;
  localparam int unsigned ESQ_W   = 18;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned BG_W    = 15;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned BINS    = 5;
  localparam int unsigned BG_N    = 25;
  localparam int unsigned BG_AW   = 5;
  localparam int unsigned LANES   = 8;

  localparam logic [HASH_W-1:0] HASH_BASIS = 64'hcbf29ce484222325;
  localparam logic [TOK_W-1:0]  TOK_MID    = 3'd2;

  localparam logic [IDX_W-1:0] IDX_PAIRS  = 6'd5;
  localparam logic [IDX_W-1:0] IDX_ENERGY = 6'd6;
  localparam logic [IDX_W-1:0] IDX_ENSQ   = 6'd7;
  localparam logic [IDX_W-1:0] IDX_HASH   = 6'd8;
  localparam logic [IDX_W-1:0] IDX_BIGRAM = 6'd9;
  localparam logic [IDX_W-1:0] IDX_LAST   = 6'd33;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAIR,
    ST_EMIT
  } state_e;

endpackage : bpts_pkg
`default_nettype wire

### design/byte_pair_token_statistics.sv
// Top level: token extraction, statistics accumulation and result run.
// Each counted byte pair is processed one token per cycle through the hash
// multiply-by-prime step; no new byte is accepted until the pair is done.
// A byte that forms no counted pair is taken without entering the pair steps.
// The last byte starts a run of 34 results, one per cycle when not stalled.
// Reset (async, active low) clears all statistics; they clear again after a run.
`default_nettype none
module byte_pair_token_statistics #(
  parameter int unsigned MAX_PAIRS = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [bpts_pkg::BYTE_W-1:0]  byte_value_i,
  input  wire logic                         last_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [bpts_pkg::IDX_W-1:0]        stat_index_o,
  output logic [bpts_pkg::HASH_W-1:0]       stat_value_o,
  output logic                              last_stat_o
);
  import bpts_pkg::*;

  localparam logic [PAIRS_W-1:0] PairsMax = PAIRS_W'(MAX_PAIRS);

  state_e              state_q, state_d;
  logic [BYTE_W-1:0]   prev_byte_q;
  logic                have_prev_q;
  logic                last_pend_q;
  logic [PAIRS_W-1:0]  pairs_q;
  logic [BYTE_W-1:0]   a_q, b_q;
  logic [STEP_W-1:0]   step_q;
  logic [TOK_W-1:0]    prev_tok_q [LANES];
  logic [HIST_W-1:0]   hist_q [BINS];
  logic [EN_W-1:0]     energy_q;
  logic [ESQ_W-1:0]    ensq_q;
  logic [HASH_W-1:0]   hash_q;
  logic [BG_W-1:0]     bg_q [BG_N];
  logic [IDX_W-1:0]    emit_idx_q;

  logic                accept;
  logic                count_pair;
  logic                load;
  logic                clear;
  logic [TOK_W-1:0]    tok;
  logic [1:0]          en;
  logic [TOK_W-1:0]    ensq;
  logic [HASH_W-1:0]   hx;
  logic [HASH_W-1:0]   hash_d;
  logic [BG_AW-1:0]    bg_tok_idx;
  logic [BG_AW-1:0]    bg_addr;
  logic [2:0]          hist_addr;
  logic [BG_W-1:0]     bg_rd;
  logic [HIST_W-1:0]   hist_rd;
  logic [HASH_W-1:0]   stat_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign count_pair = have_prev_q && (pairs_q < PairsMax);
  assign load       = (state_q == ST_EMIT) && (!out_valid_o || !out_stall_i);
  assign clear      = load && (emit_idx_q == IDX_LAST);

  always_comb begin
    if (step_q[2]) begin
      tok = {2'b00, a_q[7]} - {2'b00, a_q[6]} - {2'b00, b_q[7]} + {2'b00, b_q[6]} + TOK_MID;
    end else begin
      tok = {2'b00, a_q[7]} + {2'b00, a_q[6]} - {2'b00, b_q[7]} - {2'b00, b_q[6]} + TOK_MID;
    end
    en   = (tok >= TOK_MID) ? 2'(tok - TOK_MID) : 2'(TOK_MID - tok);
    ensq = (en == 2'd2) ? 3'd4 : {1'b0, en};
    hx   = hash_q ^ {{(HASH_W-TOK_W){1'b0}}, tok};
    hash_d = hx + (hx << 1) + (hx << 4) + (hx << 5) + (hx << 7) + (hx << 8) + (hx << 40);
    bg_tok_idx = {prev_tok_q[0], 2'b00} + {2'b00, prev_tok_q[0]} + {2'b00, tok};
  end

  always_comb begin
    if (state_q == ST_EMIT) begin
      bg_addr   = BG_AW'(emit_idx_q - IDX_BIGRAM);
      hist_addr = emit_idx_q[2:0];
    end else begin
      bg_addr   = bg_tok_idx;
      hist_addr = tok;
    end
    bg_rd   = (bg_addr < BG_AW'(BG_N)) ? bg_q[bg_addr] : '0;
    hist_rd = (hist_addr < 3'(BINS)) ? hist_q[hist_addr] : '0;
  end

  always_comb begin
    if (emit_idx_q < IDX_PAIRS) begin
      stat_val = HASH_W'(hist_rd);
    end else if (emit_idx_q == IDX_PAIRS) begin
      stat_val = HASH_W'(pairs_q);
    end else if (emit_idx_q == IDX_ENERGY) begin
      stat_val = HASH_W'(energy_q);
    end else if (emit_idx_q == IDX_ENSQ) begin
      stat_val = HASH_W'(ensq_q);
    end else if (emit_idx_q == IDX_HASH) begin
      stat_val = (pairs_q != '0) ? hash_q : '0;
    end else begin
      stat_val = HASH_W'(bg_rd);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && count_pair) begin
          state_d = ST_PAIR;
        end else if (accept && last_byte_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_PAIR: begin
        if (step_q == STEP_LAST) begin
          state_d = last_pend_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (clear) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_byte_q <= '0;
      have_prev_q <= 1'b0;
      last_pend_q <= 1'b0;
      pairs_q     <= '0;
      step_q      <= '0;
      energy_q    <= '0;
      ensq_q      <= '0;
      hash_q      <= HASH_BASIS;
      emit_idx_q  <= '0;
      for (int i = 0; i < LANES; i++) prev_tok_q[i] <= TOK_MID;
      for (int i = 0; i < BINS; i++) hist_q[i] <= '0;
      for (int i = 0; i < BG_N; i++) bg_q[i] <= '0;
    end else if (clear) begin
      prev_byte_q <= '0;
      have_prev_q <= 1'b0;
      last_pend_q <= 1'b0;
      pairs_q     <= '0;
      energy_q    <= '0;
      ensq_q      <= '0;
      hash_q      <= HASH_BASIS;
      emit_idx_q  <= '0;
      for (int i = 0; i < LANES; i++) prev_tok_q[i] <= TOK_MID;
      for (int i = 0; i < BINS; i++) hist_q[i] <= '0;
      for (int i = 0; i < BG_N; i++) bg_q[i] <= '0;
    end else begin
      if (accept) begin
        prev_byte_q <= byte_value_i;
        have_prev_q <= 1'b1;
        last_pend_q <= last_byte_i;
        step_q      <= '0;
        emit_idx_q  <= '0;
      end
      if (state_q == ST_PAIR) begin
        step_q   <= step_q + 3'd1;
        hist_q[hist_addr] <= hist_rd + 16'd1;
        energy_q <= energy_q + EN_W'(en);
        ensq_q   <= ensq_q + ESQ_W'(ensq);
        hash_q   <= hash_d;
        if (pairs_q != '0) begin
          bg_q[bg_addr] <= bg_rd + 15'd1;
        end
        for (int i = 0; i < LANES - 1; i++) prev_tok_q[i] <= prev_tok_q[i+1];
        prev_tok_q[LANES-1] <= tok;
        if (step_q == STEP_LAST) begin
          pairs_q <= pairs_q + 13'd1;
        end
      end
      if (load) begin
        emit_idx_q <= emit_idx_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= prev_byte_q;
      b_q <= byte_value_i;
    end else if (state_q == ST_PAIR) begin
      a_q <= {a_q[5:0], a_q[7:6]};
      b_q <= {b_q[5:0], b_q[7:6]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stat_index_o <= emit_idx_q;
      stat_value_o <= stat_val;
      last_stat_o  <= (emit_idx_q == IDX_LAST);
    end
  end

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_stat_o |-> stat_index_o == IDX_LAST)
    else $error("last statistic flagged at wrong index");

  a_pair_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAIR && step_q == STEP_LAST |=> pairs_q == $past(pairs_q) + 13'd1)
    else $error("pair count did not advance at end of pair");

  a_pair_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pairs_q <= PairsMax)
    else $error("pair count beyond limit");

  a_clear_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> pairs_q == '0 && hash_q == HASH_BASIS && state_q == ST_IDLE)
    else $error("state not cleared after run");

  a_no_pair_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> in_stall_o && !accept)
    else $error("byte taken during result run");

endmodule : byte_pair_token_statistics
`default_nettype wire
